FILE: rtl/sdi_pkg.sv
// Shared types, constants and tables of the strapdown delta integrator.
// Holds the datapath command and status structs, the multiply op codes and
// the CORDIC arctangent table. Depends on nothing.
`default_nettype none

package sdi_pkg;

  localparam int unsigned IN_W = 32;
  localparam int unsigned OUT_W = 48;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned STEP_W = 16;
  localparam int unsigned MUL_W = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned XY_W = 34;
  localparam int unsigned Z_W = 49;
  localparam int unsigned RACC_W = 38;
  localparam int unsigned OP_W = 5;
  localparam int unsigned TAB_SIZE = 64;
  localparam int unsigned STAGE_W = 6;
  localparam int unsigned ANG_W = 48;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;

  localparam logic [STEP_W-1:0] WINDOW_RESET = 16'd100;
  localparam logic [IN_W-1:0] PERIOD_RESET = 32'd42949673;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
  localparam logic [63:0] PI_Q43_64 = (PI_Q62 + 64'd262144) >> 19;
  localparam logic [63:0] HALF_PI_Q43_64 = ((PI_Q62 >> 1) + 64'd262144) >> 19;
  localparam logic [63:0] TWO_PI_Q43_64 = ((PI_Q62 >> 1) + 64'd65536) >> 17;
  localparam logic signed [Z_W-1:0] Z_PI = $signed(PI_Q43_64[Z_W-1:0]);
  localparam logic signed [Z_W-1:0] Z_HALF_PI = $signed(HALF_PI_Q43_64[Z_W-1:0]);
  localparam logic signed [Z_W-1:0] Z_TWO_PI = $signed(TWO_PI_Q43_64[Z_W-1:0]);
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [OP_W-1:0] {
    OP_DA0 = 5'd0, OP_DA1 = 5'd1, OP_DA2 = 5'd2,
    OP_T = 5'd3, OP_U = 5'd4, OP_M00 = 5'd5, OP_M01 = 5'd6,
    OP_M10A = 5'd7, OP_M10B = 5'd8, OP_M11A = 5'd9, OP_M11B = 5'd10,
    OP_M12 = 5'd11, OP_M20A = 5'd12, OP_M20B = 5'd13, OP_M21A = 5'd14,
    OP_M21B = 5'd15, OP_M22 = 5'd16,
    OP_RF00 = 5'd17, OP_RF01 = 5'd18, OP_RF02 = 5'd19,
    OP_RF10 = 5'd20, OP_RF11 = 5'd21, OP_RF12 = 5'd22,
    OP_RF20 = 5'd23, OP_RF21 = 5'd24, OP_RF22 = 5'd25,
    OP_V0 = 5'd26, OP_V1 = 5'd27, OP_V2 = 5'd28
  } mul_op_t;

  localparam logic [OP_W-1:0] OP_LAST_DELTA = 5'd2;
  localparam logic [OP_W-1:0] OP_FIRST_PRODUCT = 5'd3;
  localparam logic [OP_W-1:0] OP_LAST_PRODUCT = 5'd28;

  typedef struct packed {
    logic load;
    logic restart;
    logic issue;
    mul_op_t op;
    logic reduce;
    logic cordic_load;
    logic rotate;
    logic [STAGE_W-1:0] stage;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
  } dp_status_t;

  typedef logic [TAB_SIZE-1:0][ANG_W-1:0] atan_tab_t;

  function automatic logic [63:0] odd_div(input logic [63:0] v, input int unsigned k);
    case (k)
      0: return v;        1: return v / 3;    2: return v / 5;    3: return v / 7;
      4: return v / 9;    5: return v / 11;   6: return v / 13;   7: return v / 15;
      8: return v / 17;   9: return v / 19;   10: return v / 21;  11: return v / 23;
      12: return v / 25;  13: return v / 27;  14: return v / 29;  15: return v / 31;
      16: return v / 33;  17: return v / 35;  18: return v / 37;  19: return v / 39;
      20: return v / 41;  21: return v / 43;  22: return v / 45;  23: return v / 47;
      24: return v / 49;  25: return v / 51;  26: return v / 53;  27: return v / 55;
      28: return v / 57;  29: return v / 59;  30: return v / 61;
      default: return v;
    endcase
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    logic [63:0] acc;
    logic [63:0] t;
    logic [63:0] e;
    int unsigned i;
    int unsigned k;
    e = ((PI_Q62 >> 2) + 64'd262144) >> 19;
    tab[0] = e[ANG_W-1:0];
    for (i = 1; i < TAB_SIZE; i++) begin
      acc = 64'd0;
      for (k = 0; i * (2 * k + 1) < 63; k++) begin
        t = odd_div(64'h4000000000000000 >> (i * (2 * k + 1)), k);
        if (k % 2 == 1) acc = acc - t;
        else acc = acc + t;
      end
      e = (acc + 64'd262144) >> 19;
      tab[i] = e[ANG_W-1:0];
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan_tab();

  function automatic logic signed [IN_W-1:0] clamp32(input logic signed [RACC_W-1:0] v);
    if (v > $signed({{(RACC_W-IN_W+1){1'b0}}, {(IN_W-1){1'b1}}})) begin
      return {1'b0, {(IN_W-1){1'b1}}};
    end else if (v < $signed({{(RACC_W-IN_W+1){1'b1}}, {(IN_W-1){1'b0}}})) begin
      return {1'b1, {(IN_W-1){1'b0}}};
    end
    return v[IN_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sdi_ctrl.sv
// Sequencing state machine of the strapdown delta integrator.
// Owns the window counter and the window length register and drives the
// datapath through dp_cmd_t. Depends on sdi_pkg.
`default_nettype none

module sdi_ctrl
  import sdi_pkg::*;
#(
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire dp_status_t             status,
  output dp_cmd_t                     cmd
);

  typedef enum logic [7:0] {
    S_IDLE        = 8'b00000001,
    S_DELTA       = 8'b00000010,
    S_DELTA_WB    = 8'b00000100,
    S_REDUCE      = 8'b00001000,
    S_ROTATE      = 8'b00010000,
    S_PRODUCTS    = 8'b00100000,
    S_PRODUCTS_WB = 8'b01000000,
    S_FINISH      = 8'b10000000
  } ctrl_state_t;

  localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(CORDIC_STAGES - 1);

  ctrl_state_t state, state_next;
  logic [OP_W-1:0] op_index, op_index_next;
  logic [STAGE_W-1:0] stage, stage_next;
  logic [STEP_W-1:0] step_count, step_count_next;
  logic [STEP_W-1:0] window_length;
  logic out_valid_next;
  logic restart_hit;

  assign restart_hit = (step_count == window_length) || (step_count == STEP_W'(1));
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_index_next = op_index;
    stage_next = stage;
    step_count_next = step_count;
    out_valid_next = out_valid && out_stall;
    cmd = '0;
    cmd.op = mul_op_t'(op_index);
    cmd.stage = stage;
    cmd.restart = restart_hit;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          step_count_next = restart_hit ? STEP_W'(2) : step_count + STEP_W'(1);
          op_index_next = '0;
          state_next = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.issue = 1'b1;
        op_index_next = op_index + OP_W'(1);
        if (op_index == OP_LAST_DELTA) begin
          state_next = S_DELTA_WB;
        end
      end
      S_DELTA_WB: begin
        state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (status.in_range) begin
          cmd.cordic_load = 1'b1;
          stage_next = '0;
          state_next = S_ROTATE;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      S_ROTATE: begin
        cmd.rotate = 1'b1;
        stage_next = stage + STAGE_W'(1);
        if (stage == LAST_STAGE) begin
          op_index_next = OP_FIRST_PRODUCT;
          state_next = S_PRODUCTS;
        end
      end
      S_PRODUCTS: begin
        cmd.issue = 1'b1;
        op_index_next = op_index + OP_W'(1);
        if (op_index == OP_LAST_PRODUCT) begin
          state_next = S_PRODUCTS_WB;
        end
      end
      S_PRODUCTS_WB: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_index <= '0;
      stage <= '0;
      step_count <= '0;
      out_valid <= 1'b0;
      window_length <= WINDOW_RESET;
    end else begin
      state <= state_next;
      op_index <= op_index_next;
      stage <= stage_next;
      step_count <= step_count_next;
      out_valid <= out_valid_next;
      if (cfg_write && cfg_index == CFG_WINDOW_LENGTH) begin
        window_length <= cfg_data[STEP_W-1:0];
      end
    end
  end

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || !out_stall))
    else $error("result published over a beat still waiting");

  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the sample finished");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside the finish step");

  a_stage_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROTATE) |-> (stage <= LAST_STAGE))
    else $error("rotation stage out of range");

endmodule

`default_nettype wire

FILE: rtl/sdi_datapath.sv
// Datapath of the strapdown delta integrator: shared 34x34 multiplier with a
// writeback stage, three-lane iterative CORDIC, sums and result registers.
// Depends on sdi_pkg; commanded by sdi_ctrl.
`default_nettype none

module sdi_datapath
  import sdi_pkg::*;
#(
  parameter int ACCUM_WIDTH = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  status,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic signed [IN_W-1:0] rate_x,
  input  wire logic signed [IN_W-1:0] rate_y,
  input  wire logic signed [IN_W-1:0] rate_z,
  input  wire logic signed [IN_W-1:0] force_x,
  input  wire logic signed [IN_W-1:0] force_y,
  input  wire logic signed [IN_W-1:0] force_z,
  output logic signed [OUT_W-1:0]     angle_sum_x,
  output logic signed [OUT_W-1:0]     angle_sum_y,
  output logic signed [OUT_W-1:0]     angle_sum_z,
  output logic signed [OUT_W-1:0]     vel_sum_x,
  output logic signed [OUT_W-1:0]     vel_sum_y,
  output logic signed [OUT_W-1:0]     vel_sum_z,
  output logic signed [IN_W-1:0]      rotated_force_x,
  output logic signed [IN_W-1:0]      rotated_force_y,
  output logic signed [IN_W-1:0]      rotated_force_z,
  output logic                        window_restart
);

  localparam int SUM_W = ((ACCUM_WIDTH > OUT_W) ? ACCUM_WIDTH : OUT_W) + 1;
  localparam logic signed [SUM_W-1:0] ACC_HI =
    {{(SUM_W-ACCUM_WIDTH+1){1'b0}}, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;

  function automatic logic signed [ACCUM_WIDTH-1:0] sat_add(
    input logic signed [ACCUM_WIDTH-1:0] a, input logic signed [OUT_W-1:0] b);
    logic signed [SUM_W-1:0] sum;
    sum = {{(SUM_W-ACCUM_WIDTH){a[ACCUM_WIDTH-1]}}, a} +
          {{(SUM_W-OUT_W){b[OUT_W-1]}}, b};
    if (sum > ACC_HI) return ACC_HI[ACCUM_WIDTH-1:0];
    if (sum < ACC_LO) return ACC_LO[ACCUM_WIDTH-1:0];
    return sum[ACCUM_WIDTH-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] acc_out(input logic signed [ACCUM_WIDTH-1:0] v);
    logic signed [SUM_W-1:0] e;
    e = {{(SUM_W-ACCUM_WIDTH){v[ACCUM_WIDTH-1]}}, v};
    return e[OUT_W-1:0];
  endfunction

  function automatic logic signed [MUL_W-1:0] ext_in(input logic signed [IN_W-1:0] v);
    return {{(MUL_W-IN_W){v[IN_W-1]}}, v};
  endfunction

  logic [IN_W-1:0] sample_period;
  logic signed [IN_W-1:0] rate [3];
  logic signed [IN_W-1:0] frc [3];
  logic signed [Z_W-1:0] zr [3];
  logic signed [XY_W-1:0] xr [3];
  logic signed [XY_W-1:0] yr [3];
  logic neg_cos [3];
  logic signed [MUL_W-1:0] t_reg, u_reg;
  logic signed [MUL_W-1:0] m00, m01, m10, m11, m12, m20, m21, m22;
  logic signed [RACC_W-1:0] racc [3];
  logic signed [ACCUM_WIDTH-1:0] angle [3];
  logic signed [ACCUM_WIDTH-1:0] vel [3];
  logic restart_flag;
  logic signed [PROD_W-1:0] prod;
  mul_op_t wb_op;
  logic wb_valid;

  logic signed [XY_W-1:0] cs [3];
  logic signed [XY_W-1:0] sn [3];
  logic signed [MUL_W-1:0] mul_a, mul_b, dt_ext;
  logic signed [PROD_W-1:0] r30, r16;
  logic signed [MUL_W-1:0] r30m;
  logic signed [RACC_W-1:0] r30r;
  logic signed [OUT_W-1:0] r16o;
  logic signed [Z_W-1:0] z_red [3];
  logic signed [Z_W-1:0] z_ref [3];
  logic ref_neg [3];
  logic signed [XY_W-1:0] x_rot [3];
  logic signed [XY_W-1:0] y_rot [3];
  logic signed [Z_W-1:0] z_rot [3];
  logic signed [Z_W-1:0] ang;
  logic [2:0] lane_ok;

  assign dt_ext = $signed({{(MUL_W-IN_W){1'b0}}, sample_period});
  assign ang = $signed({{(Z_W-ANG_W){1'b0}}, ATAN_TAB[cmd.stage]});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cs[i] = neg_cos[i] ? -xr[i] : xr[i];
      sn[i] = yr[i];
      lane_ok[i] = (zr[i] <= Z_PI) && (zr[i] >= -Z_PI);
      if (zr[i] > Z_PI) z_red[i] = zr[i] - Z_TWO_PI;
      else if (zr[i] < -Z_PI) z_red[i] = zr[i] + Z_TWO_PI;
      else z_red[i] = zr[i];
      if (zr[i] > Z_HALF_PI) begin
        z_ref[i] = Z_PI - zr[i];
        ref_neg[i] = 1'b1;
      end else if (zr[i] < -Z_HALF_PI) begin
        z_ref[i] = -Z_PI - zr[i];
        ref_neg[i] = 1'b1;
      end else begin
        z_ref[i] = zr[i];
        ref_neg[i] = 1'b0;
      end
      if (zr[i] >= 0) begin
        x_rot[i] = xr[i] - (yr[i] >>> cmd.stage);
        y_rot[i] = yr[i] + (xr[i] >>> cmd.stage);
        z_rot[i] = zr[i] - ang;
      end else begin
        x_rot[i] = xr[i] + (yr[i] >>> cmd.stage);
        y_rot[i] = yr[i] - (xr[i] >>> cmd.stage);
        z_rot[i] = zr[i] + ang;
      end
    end
    status.in_range = &lane_ok;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_DA0:  begin mul_a = ext_in(rate[0]); mul_b = dt_ext; end
      OP_DA1:  begin mul_a = ext_in(rate[1]); mul_b = dt_ext; end
      OP_DA2:  begin mul_a = ext_in(rate[2]); mul_b = dt_ext; end
      OP_T:    begin mul_a = cs[2]; mul_b = sn[1]; end
      OP_U:    begin mul_a = sn[2]; mul_b = sn[1]; end
      OP_M00:  begin mul_a = cs[2]; mul_b = cs[1]; end
      OP_M01:  begin mul_a = sn[2]; mul_b = cs[1]; end
      OP_M10A: begin mul_a = t_reg; mul_b = sn[0]; end
      OP_M10B: begin mul_a = sn[2]; mul_b = cs[0]; end
      OP_M11A: begin mul_a = u_reg; mul_b = sn[0]; end
      OP_M11B: begin mul_a = cs[2]; mul_b = cs[0]; end
      OP_M12:  begin mul_a = cs[1]; mul_b = sn[0]; end
      OP_M20A: begin mul_a = t_reg; mul_b = cs[0]; end
      OP_M20B: begin mul_a = sn[2]; mul_b = sn[0]; end
      OP_M21A: begin mul_a = u_reg; mul_b = cs[0]; end
      OP_M21B: begin mul_a = cs[2]; mul_b = sn[0]; end
      OP_M22:  begin mul_a = cs[1]; mul_b = cs[0]; end
      OP_RF00: begin mul_a = m00; mul_b = ext_in(frc[0]); end
      OP_RF01: begin mul_a = m01; mul_b = ext_in(frc[1]); end
      OP_RF02: begin mul_a = -sn[1]; mul_b = ext_in(frc[2]); end
      OP_RF10: begin mul_a = m10; mul_b = ext_in(frc[0]); end
      OP_RF11: begin mul_a = m11; mul_b = ext_in(frc[1]); end
      OP_RF12: begin mul_a = m12; mul_b = ext_in(frc[2]); end
      OP_RF20: begin mul_a = m20; mul_b = ext_in(frc[0]); end
      OP_RF21: begin mul_a = m21; mul_b = ext_in(frc[1]); end
      OP_RF22: begin mul_a = m22; mul_b = ext_in(frc[2]); end
      OP_V0:   begin mul_a = ext_in(clamp32(racc[0])); mul_b = dt_ext; end
      OP_V1:   begin mul_a = ext_in(clamp32(racc[1])); mul_b = dt_ext; end
      OP_V2:   begin mul_a = ext_in(clamp32(racc[2])); mul_b = dt_ext; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign r30 = (prod + $signed(PROD_W'(1) << 29)) >>> 30;
  assign r16 = prod >>> 16;
  assign r30m = r30[MUL_W-1:0];
  assign r30r = r30[RACC_W-1:0];
  assign r16o = r16[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
      sample_period <= PERIOD_RESET;
      for (int i = 0; i < 3; i++) begin
        angle[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      wb_valid <= cmd.issue;
      if (cfg_write && cfg_index == CFG_SAMPLE_PERIOD) begin
        sample_period <= cfg_data[IN_W-1:0];
      end
      if (cmd.load && cmd.restart) begin
        for (int i = 0; i < 3; i++) begin
          angle[i] <= '0;
          vel[i] <= '0;
        end
      end
      if (wb_valid) begin
        case (wb_op)
          OP_DA0: angle[0] <= sat_add(angle[0], r16o);
          OP_DA1: angle[1] <= sat_add(angle[1], r16o);
          OP_DA2: angle[2] <= sat_add(angle[2], r16o);
          OP_V0:  vel[0] <= sat_add(vel[0], r16o);
          OP_V1:  vel[1] <= sat_add(vel[1], r16o);
          OP_V2:  vel[2] <= sat_add(vel[2], r16o);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      prod <= mul_a * mul_b;
      wb_op <= cmd.op;
    end
    if (cmd.load) begin
      rate[0] <= rate_x;
      rate[1] <= rate_y;
      rate[2] <= rate_z;
      frc[0] <= force_x;
      frc[1] <= force_y;
      frc[2] <= force_z;
      restart_flag <= cmd.restart;
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.reduce) begin
        zr[i] <= z_red[i];
      end
      if (cmd.cordic_load) begin
        zr[i] <= z_ref[i];
        neg_cos[i] <= ref_neg[i];
        xr[i] <= CORDIC_GAIN;
        yr[i] <= '0;
      end
      if (cmd.rotate) begin
        xr[i] <= x_rot[i];
        yr[i] <= y_rot[i];
        zr[i] <= z_rot[i];
      end
    end
    if (wb_valid) begin
      case (wb_op)
        OP_DA0:  zr[0] <= {r16o[OUT_W-1], r16o};
        OP_DA1:  zr[1] <= {r16o[OUT_W-1], r16o};
        OP_DA2:  zr[2] <= {r16o[OUT_W-1], r16o};
        OP_T:    t_reg <= r30m;
        OP_U:    u_reg <= r30m;
        OP_M00:  m00 <= r30m;
        OP_M01:  m01 <= r30m;
        OP_M10A: m10 <= r30m;
        OP_M10B: m10 <= m10 - r30m;
        OP_M11A: m11 <= r30m;
        OP_M11B: m11 <= m11 + r30m;
        OP_M12:  m12 <= r30m;
        OP_M20A: m20 <= r30m;
        OP_M20B: m20 <= m20 + r30m;
        OP_M21A: m21 <= r30m;
        OP_M21B: m21 <= m21 - r30m;
        OP_M22:  m22 <= r30m;
        OP_RF00: racc[0] <= r30r;
        OP_RF01: racc[0] <= racc[0] + r30r;
        OP_RF02: racc[0] <= racc[0] + r30r;
        OP_RF10: racc[1] <= r30r;
        OP_RF11: racc[1] <= racc[1] + r30r;
        OP_RF12: racc[1] <= racc[1] + r30r;
        OP_RF20: racc[2] <= r30r;
        OP_RF21: racc[2] <= racc[2] + r30r;
        OP_RF22: racc[2] <= racc[2] + r30r;
        default: begin
        end
      endcase
    end
    if (cmd.publish) begin
      angle_sum_x <= acc_out(angle[0]);
      angle_sum_y <= acc_out(angle[1]);
      angle_sum_z <= acc_out(angle[2]);
      vel_sum_x <= acc_out(vel[0]);
      vel_sum_y <= acc_out(vel[1]);
      vel_sum_z <= acc_out(vel[2]);
      rotated_force_x <= clamp32(racc[0]);
      rotated_force_y <= clamp32(racc[1]);
      rotated_force_z <= clamp32(racc[2]);
      window_restart <= restart_flag;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/strapdown_delta_integrator.sv
// Top level of the strapdown delta integrator: joins the sequencer and the
// datapath. Depends on sdi_pkg, sdi_ctrl and sdi_datapath.
//
//   beat      handshake              payload
//   input     in_valid / in_stall    rate_x..z, force_x..z
//   output    out_valid / out_stall  angle_sum_*, vel_sum_*, rotated_force_*, window_restart
//   config    cfg_write              cfg_index, cfg_data
//
// Each sample goes through the shared multiplier for the angle deltas, range
// reduction of the angles, the iterative three-lane CORDIC and the shared
// multiplier again for the products. One sample is worked on at a time.
// Reset is synchronous and needs no clearing pass. A finished result waits in
// the output registers; a new sample may be taken meanwhile and only its
// publish step waits for out_stall to drop.
`default_nettype none

module strapdown_delta_integrator
  import sdi_pkg::*;
#(
  parameter int CORDIC_STAGES = 24,
  parameter int ACCUM_WIDTH = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic signed [IN_W-1:0] rate_x,
  input  wire logic signed [IN_W-1:0] rate_y,
  input  wire logic signed [IN_W-1:0] rate_z,
  input  wire logic signed [IN_W-1:0] force_x,
  input  wire logic signed [IN_W-1:0] force_y,
  input  wire logic signed [IN_W-1:0] force_z,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [OUT_W-1:0]     angle_sum_x,
  output logic signed [OUT_W-1:0]     angle_sum_y,
  output logic signed [OUT_W-1:0]     angle_sum_z,
  output logic signed [OUT_W-1:0]     vel_sum_x,
  output logic signed [OUT_W-1:0]     vel_sum_y,
  output logic signed [OUT_W-1:0]     vel_sum_z,
  output logic signed [IN_W-1:0]      rotated_force_x,
  output logic signed [IN_W-1:0]      rotated_force_y,
  output logic signed [IN_W-1:0]      rotated_force_z,
  output logic                        window_restart,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  dp_cmd_t cmd;
  dp_status_t status;

  sdi_ctrl #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .status(status),
    .cmd(cmd)
  );

  sdi_datapath #(
    .ACCUM_WIDTH(ACCUM_WIDTH)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .rate_x(rate_x),
    .rate_y(rate_y),
    .rate_z(rate_z),
    .force_x(force_x),
    .force_y(force_y),
    .force_z(force_z),
    .angle_sum_x(angle_sum_x),
    .angle_sum_y(angle_sum_y),
    .angle_sum_z(angle_sum_z),
    .vel_sum_x(vel_sum_x),
    .vel_sum_y(vel_sum_y),
    .vel_sum_z(vel_sum_z),
    .rotated_force_x(rotated_force_x),
    .rotated_force_y(rotated_force_y),
    .rotated_force_z(rotated_force_z),
    .window_restart(window_restart)
  );

endmodule

`default_nettype wire
